>>> rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg: shared types and constants of the integer to ASCII formatter
// Job record between front and back, back-end state codes, mode codes and
// the ASCII glyphs used for the text.
// ----------------------------------------------------------------------------
`default_nettype none

package itaf_pkg;

    // Width of the binary operand
    localparam int BIN_W   = 64;
    localparam int BIT_CW  = $clog2(BIN_W);

    // Format modes
    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_PTR  = 2'd3;

    // Fixed characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;

    // Pointer form always prints this many hex digits
    localparam int PTR_DIGITS = 16;

    // One classified value waiting for conversion
    typedef struct packed {
        logic [BIN_W-1:0] mag;   // magnitude (or raw bits for hex forms)
        logic [1:0]       mode;
        logic             neg;   // signed decimal and negative
    } job_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_PFX0,
        ST_PFXX,
        ST_DIG
    } state_t;

    // Digit value to uppercase hex / decimal glyph
    function automatic logic [7:0] glyph(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            4'hF: c = 8'h46;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/itaf_front.sv
// ----------------------------------------------------------------------------
// itaf_front: input classification and job queue
// Accepts a value and mode, resolves sign and magnitude, and holds the
// result in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [itaf_pkg::BIN_W-1:0] value,
    input  wire logic [1:0]                 mode,
    output logic                            job_valid,
    input  wire logic                       job_ready,
    output itaf_pkg::job_t                  job
);

    localparam int DEPTH = 2;

    itaf_pkg::job_t q_mem [DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push, pop;
    itaf_pkg::job_t cls;

    // Classify: signed decimal negatives become magnitude plus sign flag
    always_comb
    begin
        cls.mode = mode;
        cls.neg  = (mode == itaf_pkg::MODE_SDEC) && value[itaf_pkg::BIN_W-1];
        cls.mag  = cls.neg ? (itaf_pkg::BIN_W'(0) - value) : value;
    end

    assign s_tready  = (fill_reg != 2'(DEPTH));
    assign push      = s_tvalid && s_tready;
    assign job_valid = (fill_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> rtl/itaf_back.sv
// ----------------------------------------------------------------------------
// itaf_back: digit generation and character emission
// Decimal jobs run a bit-serial double-dabble over every operand bit; hex jobs
// load nibbles directly. Digits then leave from the top of the digit register,
// leading zeros skipped, behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itaf_back
#(
    parameter int MAX_CHARS = 20
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire itaf_pkg::job_t job,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          ch,
    output logic                last
);

    localparam int DW = 4 * MAX_CHARS;
    localparam int CW = $clog2(MAX_CHARS + 1);

    itaf_pkg::state_t               state_reg, state_next;
    logic [DW-1:0]                  dig_reg, dig_next;
    logic [itaf_pkg::BIN_W-1:0]     bin_reg, bin_next;
    logic [itaf_pkg::BIT_CW-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           ptr_reg, ptr_next;
    logic                           neg_reg, neg_next;
    logic                           started_reg, started_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_ch_reg, out_ch_next;
    logic                           out_last_reg, out_last_next;

    logic                           out_free;
    logic [3:0]                     top;
    logic [CW-1:0]                  min_len;
    logic                           skip;
    logic                           conv_done;
    logic [DW-1:0]                  adj;

    assign out_free  = !out_valid_reg || m_tready;
    assign top       = dig_reg[DW-1 -: 4];
    assign min_len   = ptr_reg ? CW'(itaf_pkg::PTR_DIGITS) : CW'(1);
    assign skip      = !started_reg && (top == 4'd0) && (cnt_reg > min_len);
    assign conv_done = (bit_cnt_reg == itaf_pkg::BIT_CW'(itaf_pkg::BIN_W - 1));
    assign job_ready = (state_reg == itaf_pkg::ST_IDLE);

    assign m_tvalid = out_valid_reg;
    assign ch       = out_ch_reg;
    assign last     = out_last_reg;

    // Double-dabble correction: add 3 to every digit of 5 or more
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            d = dig_reg[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    case (job.mode)
                        itaf_pkg::MODE_HEX: state_next = itaf_pkg::ST_DIG;
                        itaf_pkg::MODE_PTR: state_next = itaf_pkg::ST_PFX0;
                        default:            state_next = itaf_pkg::ST_CONV;
                    endcase
                end
            end
            itaf_pkg::ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = neg_reg ? itaf_pkg::ST_SIGN : itaf_pkg::ST_DIG;
                end
            end
            itaf_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = itaf_pkg::ST_DIG;
                end
            end
            itaf_pkg::ST_PFX0:
            begin
                if (out_free)
                begin
                    state_next = itaf_pkg::ST_PFXX;
                end
            end
            itaf_pkg::ST_PFXX:
            begin
                if (out_free)
                begin
                    state_next = itaf_pkg::ST_DIG;
                end
            end
            itaf_pkg::ST_DIG:
            begin
                if (!skip && out_free && (cnt_reg == CW'(1)))
                begin
                    state_next = itaf_pkg::ST_IDLE;
                end
            end
            default: state_next = itaf_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        dig_next       = dig_reg;
        bin_next       = bin_reg;
        bit_cnt_next   = bit_cnt_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            itaf_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    dig_next     = DW'(job.mag);
                    bin_next     = job.mag;
                    bit_cnt_next = '0;
                    cnt_next     = CW'(MAX_CHARS);
                    ptr_next     = (job.mode == itaf_pkg::MODE_PTR);
                    neg_next     = job.neg;
                    started_next = 1'b0;
                    if (job.mode == itaf_pkg::MODE_SDEC || job.mode == itaf_pkg::MODE_UDEC)
                    begin
                        dig_next = '0;
                    end
                end
            end
            itaf_pkg::ST_CONV:
            begin
                dig_next     = {adj[DW-2:0], bin_reg[itaf_pkg::BIN_W-1]};
                bin_next     = {bin_reg[itaf_pkg::BIN_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + itaf_pkg::BIT_CW'(1);
            end
            itaf_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = itaf_pkg::CH_MINUS;
                    out_last_next  = 1'b0;
                end
            end
            itaf_pkg::ST_PFX0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = itaf_pkg::CH_ZERO;
                    out_last_next  = 1'b0;
                end
            end
            itaf_pkg::ST_PFXX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = itaf_pkg::CH_X;
                    out_last_next  = 1'b0;
                end
            end
            itaf_pkg::ST_DIG:
            begin
                if (skip)
                begin
                    dig_next = {dig_reg[DW-5:0], 4'd0};
                    cnt_next = cnt_reg - CW'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = itaf_pkg::glyph(top);
                    out_last_next  = (cnt_reg == CW'(1));
                    dig_next       = {dig_reg[DW-5:0], 4'd0};
                    cnt_next       = cnt_reg - CW'(1);
                    started_next   = 1'b1;
                end
            end
            default:
            begin
                started_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itaf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dig_reg      <= dig_next;
        bin_reg      <= bin_next;
        bit_cnt_reg  <= bit_cnt_next;
        cnt_reg      <= cnt_next;
        ptr_reg      <= ptr_next;
        neg_reg      <= neg_next;
        started_reg  <= started_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

>>> rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: 64-bit integer to ASCII text
// Signed/unsigned decimal, uppercase hex and 0x pointer form, one character
// per output transaction, most significant first, tlast on the final one.
//
//   channel | dir | tdata              | tuser     | tlast
//   s_*     | in  | [63:0] value       | [1:0] mode| -
//   m_*     | out | [7:0] ch           | -         | last
//
// The back end takes a job, runs the double-dabble loop for decimal, emits
// a minus sign if negative, then steps through each digit position (20),
// skipping or emitting it; hex and pointer jobs skip the loop; output stalls hold it.
// A two-entry job queue lets new values arrive while the back end works;
// the output register lets the back end run while a character waits.
// Reset clears the queue, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_core
#(
    parameter int MAX_CHARS = 20
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] ch
    output logic             m_tlast
);

    logic           job_valid;
    logic           job_ready;
    itaf_pkg::job_t job;

    // Front: classify and queue
    itaf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .value     (s_tdata),
        .mode      (s_tuser),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Back: convert and emit
    itaf_back
    #(
        .MAX_CHARS (MAX_CHARS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .ch        (m_tdata),
        .last      (m_tlast)
    );

endmodule

`default_nettype wire

>>> tb/itaf_text_check_pkg.sv
// ----------------------------------------------------------------------------
// itaf_text_check_pkg: expected-text scoreboard for the ASCII formatter
// Predicts the character stream of every accepted value and checks each
// output transaction against the oldest pending character.
// ----------------------------------------------------------------------------
`default_nettype none

package itaf_text_check_pkg;

    import itaf_pkg::*;

    // Longest text the formatter may emit for one value
    localparam int TEXT_MAX   = 20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    class text_scoreboard;

        logic [7:0] expected_chars[$];
        bit         expected_last[$];
        int         mismatches;
        int         values_seen;
        int         chars_seen;
        int         mode_count[4];

        function new();
            mismatches  = 0;
            values_seen = 0;
            chars_seen  = 0;
            foreach (mode_count[i])
                mode_count[i] = 0;
        endfunction

        // Nibble to uppercase hex or decimal glyph
        function logic [7:0] nibble_glyph(logic [3:0] d);
            if (d < 4'd10)
                return CH_ZERO + 8'(d);
            return CH_UPPER_A + 8'(d - 4'd10);
        endfunction

        // Work out the text of one accepted value and queue its characters
        function void predict_text(logic [63:0] value, logic [1:0] mode);
            logic [7:0]  rev[$];
            logic [63:0] mag;
            bit          neg;
            int          k;
            mag = value;
            neg = (mode == MODE_SDEC) && value[63];
            if (neg)
                mag = 64'd0 - value;
            case (mode)
                MODE_PTR:
                begin
                    for (k = 0; k < PTR_DIGITS; k++)
                    begin
                        rev.push_back(nibble_glyph(mag[3:0]));
                        mag = mag >> 4;
                    end
                    rev.push_back(CH_X);
                    rev.push_back(CH_ZERO);
                end
                MODE_HEX:
                begin
                    do
                    begin
                        rev.push_back(nibble_glyph(mag[3:0]));
                        mag = mag >> 4;
                    end while (mag != 64'd0 && rev.size() < TEXT_MAX);
                end
                default:
                begin
                    do
                    begin
                        rev.push_back(CH_ZERO + 8'(mag % 64'd10));
                        mag = mag / 64'd10;
                    end while (mag != 64'd0 && rev.size() < TEXT_MAX);
                end
            endcase
            if (neg && rev.size() < TEXT_MAX)
                rev.push_back(CH_MINUS);
            // most significant character first
            for (k = rev.size() - 1; k >= 0; k--)
            begin
                expected_chars.push_back(rev[k]);
                expected_last.push_back(k == 0);
            end
            values_seen++;
            mode_count[mode]++;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one output transaction with the oldest expectation
        task check_char(logic [7:0] ch, logic last);
            logic [7:0] want_ch;
            bit         want_last;
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            want_ch   = expected_chars.pop_front();
            want_last = expected_last.pop_front();
            if (ch !== want_ch)
                report($sformatf("char %0d: got 0x%02h, want 0x%02h",
                                 chars_seen, ch, want_ch));
            if (last !== want_last)
                report($sformatf("char %0d: last got %0b, want %0b",
                                 chars_seen, last, want_last));
        endtask

        function int pending();
            return expected_chars.size();
        endfunction

    endclass

endpackage

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of integer_to_ascii_formatter_core
// Drives directed corner values and random values in all four modes, with
// random idle bursts on both stream sides, and checks every character and
// its tlast against the scoreboard's predicted text.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import itaf_pkg::*;
    import itaf_text_check_pkg::*;

    localparam int RANDOM_VALUES = 248;
    localparam int CALM_TAIL     = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = 64'd0;
    logic [1:0]  s_tuser  = MODE_SDEC;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    text_scoreboard board;
    bit             idle_on    = 1'b1;
    int             stall_left = 0;
    int             cycle_count = 0;

    always #6 clk = ~clk;

    integer_to_ascii_formatter_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: check accepted characters, stall in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                board.check_char(m_tdata, m_tlast);
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Input side: one transaction, with an optional idle gap in front
    task automatic send_value(input logic [63:0] value, input logic [1:0] mode);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        board.predict_text(value, mode);
    endtask

    // Corner values: zero, all ones, sign boundaries, digit-count edges
    task automatic run_corners();
        send_value(64'd0, MODE_SDEC);
        send_value(64'd0, MODE_UDEC);
        send_value(64'd0, MODE_HEX);
        send_value(64'd0, MODE_PTR);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_PTR);
        // most negative signed value keeps magnitude 2^63
        send_value(64'h8000_0000_0000_0000, MODE_SDEC);
        send_value(64'h8000_0000_0000_0000, MODE_UDEC);
        send_value(64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC);
        send_value(64'hFFFF_FFFF_FFFF_FFF6, MODE_SDEC);
        send_value(64'd1, MODE_SDEC);
        send_value(64'd9, MODE_UDEC);
        send_value(64'd10, MODE_UDEC);
        send_value(64'd15, MODE_HEX);
        send_value(64'd16, MODE_HEX);
        send_value(64'd9999999999999999999, MODE_UDEC);
        send_value(64'd10000000000000000000, MODE_UDEC);
        send_value(64'h0123_4567_89AB_CDEF, MODE_PTR);
        send_value(64'hFEDC_BA98_7654_3210, MODE_HEX);
        send_value(64'h0000_0000_0000_00A0, MODE_PTR);
    endtask

    // Random operand with a spread of digit counts
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2:
            begin
                p = 64'd1;
                for (k = $urandom_range(0, 19); k > 0; k--)
                    p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: v = 64'd0 - 64'($urandom_range(1, 1000));
            default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    task automatic run_random();
        int n;
        for (n = 0; n < RANDOM_VALUES; n++)
        begin
            // calm stretches now and then, and calm throughout near the end
            if (n >= RANDOM_VALUES - CALM_TAIL)
                idle_on = 1'b0;
            else if (n % 30 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_value(pick_value(), 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_corners();
        run_random();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        $display("Covered %0d values: %0d signed dec, %0d unsigned dec, %0d hex, %0d pointer",
                 board.values_seen, board.mode_count[MODE_SDEC],
                 board.mode_count[MODE_UDEC], board.mode_count[MODE_HEX],
                 board.mode_count[MODE_PTR]);
        $display("Checked %0d characters, %0d mismatches",
                 board.chars_seen, board.mismatches);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
